>>> design/rmm2d_pkg.sv
// ============================================================================
// Two-dimensional min/max segment tree: shared types and constants
// Field widths, value identities, operation codes and default dimensions.
// ============================================================================
package rmm2d_pkg;

	// Field widths fixed by the command format.
	localparam int COORD_W = 6;
	localparam int VAL_W   = 32;

	// Default matrix dimensions.
	localparam int DEF_ROWS = 64;
	localparam int DEF_COLS = 64;

	// Identities of the minimum and the maximum.
	localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;

	// Operation codes.
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// One command beat.
	typedef struct packed {
		logic                      operation;
		logic [COORD_W-1:0]        row_low;
		logic [COORD_W-1:0]        row_high;
		logic [COORD_W-1:0]        col_low;
		logic [COORD_W-1:0]        col_high;
		logic signed [VAL_W-1:0]   cell_value;
	} in_t;

	// One result beat.
	typedef struct packed {
		logic signed [VAL_W-1:0] rect_min;
		logic signed [VAL_W-1:0] rect_max;
	} out_t;

	// One tree node: minimum and maximum side by side.
	typedef struct packed {
		logic signed [VAL_W-1:0] min_v;
		logic signed [VAL_W-1:0] max_v;
	} word_t;

	// Combine two nodes.
	function automatic word_t merge(input word_t a, input word_t b);
		word_t r;
		r.min_v = (a.min_v < b.min_v) ? a.min_v : b.min_v;
		r.max_v = (a.max_v > b.max_v) ? a.max_v : b.max_v;
		return r;
	endfunction

endpackage

>>> design/rect_min_max_2d_segment_tree.sv
// ============================================================================
// Two-dimensional min/max segment tree
// Point updates and rectangle min/max queries over a ROWS by COLS matrix.
// ============================================================================
// After reset the block sweeps all 2**(clog2(ROWS)+clog2(COLS)+2) entries
// (16384 at 64 by 64) of its node memory once, one entry per cycle, with
// busy high. Then an item is taken when start is high and busy is low. An
// update walks down both trees and then refreshes, from the cell upwards,
// each of the up to (clog2(ROWS)+1)*(clog2(COLS)+1) nodes on the cross
// product of its row and column paths, the cell included: the cell takes
// the new value, and every other node is rebuilt from two reads and one
// write of the node memory, which has one read and one write port. It
// gives no result. A query walks the row tree with a stack and, for each
// row node inside the rectangle, that node's column tree, reading and
// merging each column node inside it. It gives exactly one result beat on
// done and result; an empty rectangle answers in the cycle after it is
// taken. The receiver cannot stall: a result is shown for exactly one
// cycle.
module rect_min_max_2d_segment_tree #(
	parameter int ROWS = rmm2d_pkg::DEF_ROWS,
	parameter int COLS = rmm2d_pkg::DEF_COLS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rmm2d_pkg::in_t   cmd,
	output logic             done,
	output rmm2d_pkg::out_t  result
);

	localparam int RL    = $clog2(ROWS);
	localparam int CL    = $clog2(COLS);
	localparam int RB    = (RL > 0) ? RL : 1;
	localparam int CB    = (CL > 0) ? CL : 1;
	localparam int RNW   = RL + 1;
	localparam int CNW   = CL + 1;
	localparam int AW    = RNW + CNW;
	localparam int RPL   = RL + 1;
	localparam int CPL   = CL + 1;
	localparam int RDW   = (RPL > 1) ? $clog2(RPL) : 1;
	localparam int CDW   = (CPL > 1) ? $clog2(CPL) : 1;
	localparam int RSD   = RL + 2;
	localparam int CSD   = CL + 2;
	localparam int RSIW  = $clog2(RSD);
	localparam int CSIW  = $clog2(CSD);
	localparam int RSPW  = $clog2(RSD + 1);
	localparam int CSPW  = $clog2(CSD + 1);
	localparam int MB    = (RB > CB) ? RB : CB;
	localparam int CMPW  = (MB > rmm2d_pkg::COORD_W) ? MB : rmm2d_pkg::COORD_W;
	localparam logic [RB-1:0] ROW_LAST = RB'(ROWS - 1);
	localparam logic [CB-1:0] COL_LAST = CB'(COLS - 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DESC, S_UA, S_UB, S_UW, S_RPOP, S_CPOP, S_CWAIT
	} state_t;

	localparam rmm2d_pkg::word_t EMPTY = '{min_v: rmm2d_pkg::INT_MAX,
		max_v: rmm2d_pkg::INT_MIN};

	state_t state_q;
	logic [AW-1:0] clr_q;
	rmm2d_pkg::in_t cmd_q;

	// Descent registers for updates.
	logic [RNW-1:0] dr_v_q;
	logic [RB-1:0]  dr_s_q, dr_e_q;
	logic [RDW-1:0] dr_d_q;
	logic [CNW-1:0] dc_v_q;
	logic [CB-1:0]  dc_s_q, dc_e_q;
	logic [CDW-1:0] dc_d_q;
	logic [RNW-1:0] rnode_q [RPL];
	logic [CNW-1:0] cnode_q [CPL];
	logic [RDW-1:0] ri_q;
	logic [CDW-1:0] ci_q;
	rmm2d_pkg::word_t a_q;

	// Query stacks and accumulators.
	logic [RNW-1:0] rs_node_q [RSD];
	logic [RB-1:0]  rs_lo_q   [RSD];
	logic [RB-1:0]  rs_hi_q   [RSD];
	logic [CNW-1:0] cs_node_q [CSD];
	logic [CB-1:0]  cs_lo_q   [CSD];
	logic [CB-1:0]  cs_hi_q   [CSD];
	logic [RSPW-1:0] rsp_q;
	logic [CSPW-1:0] csp_q;
	logic [RNW-1:0]  vx_q;
	rmm2d_pkg::word_t acc_q;
	logic done_q;
	rmm2d_pkg::out_t res_q;

	// Node memory.
	rmm2d_pkg::word_t mem [2**AW];
	rmm2d_pkg::word_t rd_q;
	logic             mem_we;
	logic [AW-1:0]    mem_wa, mem_ra;
	rmm2d_pkg::word_t mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	// Update walk: current node, its children and the next position.
	logic [RNW-1:0] ux;
	logic [CNW-1:0] uy;
	logic           rleaf, cleaf;
	logic [AW-1:0]  addr_a, addr_b;
	logic [RDW-1:0] nxt_ri;
	logic [CDW-1:0] nxt_ci;
	logic           walk_end;

	always_comb begin
		ux    = rnode_q[ri_q];
		uy    = cnode_q[ci_q];
		rleaf = (ri_q == dr_d_q);
		cleaf = (ci_q == dc_d_q);
		if (!cleaf) begin
			addr_a = {ux, CNW'({1'b0, uy} << 1) + CNW'(1)};
			addr_b = {ux, CNW'({1'b0, uy} << 1) + CNW'(2)};
		end else begin
			addr_a = {RNW'({1'b0, ux} << 1) + RNW'(1), uy};
			addr_b = {RNW'({1'b0, ux} << 1) + RNW'(2), uy};
		end
		walk_end = (ci_q == '0) && (ri_q == '0);
		if (ci_q != '0) begin
			nxt_ri = ri_q;
			nxt_ci = ci_q - 1'b1;
		end else begin
			nxt_ri = ri_q - 1'b1;
			nxt_ci = dc_d_q;
		end
	end

	// Descent midpoints.
	logic [RB-1:0] dr_mid;
	logic [CB-1:0] dc_mid;
	assign dr_mid = RB'(({1'b0, dr_s_q} + {1'b0, dr_e_q}) >> 1);
	assign dc_mid = CB'(({1'b0, dc_s_q} + {1'b0, dc_e_q}) >> 1);

	// Row stack top and its tests against the query rectangle.
	logic [RSPW-1:0] rsp_m1;
	logic [RSIW-1:0] rtop, rpush;
	logic [RNW-1:0]  rv;
	logic [RB-1:0]   rs, re, rm;
	logic            r_disj, r_cov;
	logic [CMPW-1:0] x1, x2, y1, y2;

	always_comb begin
		x1     = CMPW'(cmd_q.row_low);
		x2     = CMPW'(cmd_q.row_high);
		y1     = CMPW'(cmd_q.col_low);
		y2     = CMPW'(cmd_q.col_high);
		rsp_m1 = rsp_q - 1'b1;
		rtop   = rsp_m1[RSIW-1:0];
		rpush  = rsp_q[RSIW-1:0];
		rv     = rs_node_q[rtop];
		rs     = rs_lo_q[rtop];
		re     = rs_hi_q[rtop];
		rm     = RB'(({1'b0, rs} + {1'b0, re}) >> 1);
		r_disj = (x2 < CMPW'(rs)) || (CMPW'(re) < x1);
		r_cov  = (x1 <= CMPW'(rs)) && (CMPW'(re) <= x2);
	end

	// Column stack top.
	logic [CSPW-1:0] csp_m1;
	logic [CSIW-1:0] ctop, cpush;
	logic [CNW-1:0]  cv;
	logic [CB-1:0]   cs, ce, cm;
	logic            c_disj, c_cov;

	always_comb begin
		csp_m1 = csp_q - 1'b1;
		ctop   = csp_m1[CSIW-1:0];
		cpush  = csp_q[CSIW-1:0];
		cv     = cs_node_q[ctop];
		cs     = cs_lo_q[ctop];
		ce     = cs_hi_q[ctop];
		cm     = CB'(({1'b0, cs} + {1'b0, ce}) >> 1);
		c_disj = (y2 < CMPW'(cs)) || (CMPW'(ce) < y1);
		c_cov  = (y1 <= CMPW'(cs)) && (CMPW'(ce) <= y2);
	end

	// Memory port selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = EMPTY;
		mem_ra = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_UA: begin
				if (rleaf && cleaf) begin
					mem_we = 1'b1;
					mem_wa = {ux, uy};
					mem_wd = '{min_v: cmd_q.cell_value, max_v: cmd_q.cell_value};
				end else begin
					mem_ra = addr_a;
				end
			end
			S_UB: begin
				mem_ra = addr_b;
			end
			S_UW: begin
				mem_we = 1'b1;
				mem_wa = {ux, uy};
				mem_wd = rmm2d_pkg::merge(a_q, rd_q);
			end
			S_CPOP: begin
				mem_ra = {vx_q, cv};
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
			csp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						if (cmd.operation == rmm2d_pkg::OP_UPDATE) begin
							if (int'(cmd.row_low) < ROWS && int'(cmd.col_low) < COLS) begin
								dr_v_q  <= '0;
								dr_s_q  <= '0;
								dr_e_q  <= ROW_LAST;
								dr_d_q  <= '0;
								dc_v_q  <= '0;
								dc_s_q  <= '0;
								dc_e_q  <= COL_LAST;
								dc_d_q  <= '0;
								state_q <= S_DESC;
							end
						end else if (cmd.row_low > cmd.row_high
							|| cmd.col_low > cmd.col_high) begin
							done_q         <= 1'b1;
							res_q.rect_min <= rmm2d_pkg::INT_MAX;
							res_q.rect_max <= rmm2d_pkg::INT_MIN;
						end else begin
							rs_node_q[0] <= '0;
							rs_lo_q[0]   <= '0;
							rs_hi_q[0]   <= ROW_LAST;
							rsp_q        <= RSPW'(1);
							acc_q        <= EMPTY;
							state_q      <= S_RPOP;
						end
					end
				end
				S_DESC: begin
					// Record the path one level per cycle in both trees.
					rnode_q[dr_d_q] <= dr_v_q;
					cnode_q[dc_d_q] <= dc_v_q;
					if (dr_s_q != dr_e_q) begin
						dr_d_q <= dr_d_q + 1'b1;
						if (CMPW'(cmd_q.row_low) <= CMPW'(dr_mid)) begin
							dr_v_q <= RNW'({1'b0, dr_v_q} << 1) + RNW'(1);
							dr_e_q <= dr_mid;
						end else begin
							dr_v_q <= RNW'({1'b0, dr_v_q} << 1) + RNW'(2);
							dr_s_q <= dr_mid + 1'b1;
						end
					end
					if (dc_s_q != dc_e_q) begin
						dc_d_q <= dc_d_q + 1'b1;
						if (CMPW'(cmd_q.col_low) <= CMPW'(dc_mid)) begin
							dc_v_q <= CNW'({1'b0, dc_v_q} << 1) + CNW'(1);
							dc_e_q <= dc_mid;
						end else begin
							dc_v_q <= CNW'({1'b0, dc_v_q} << 1) + CNW'(2);
							dc_s_q <= dc_mid + 1'b1;
						end
					end
					if (dr_s_q == dr_e_q && dc_s_q == dc_e_q) begin
						ri_q    <= dr_d_q;
						ci_q    <= dc_d_q;
						state_q <= S_UA;
					end
				end
				S_UA: begin
					if (rleaf && cleaf) begin
						ri_q    <= nxt_ri;
						ci_q    <= nxt_ci;
						state_q <= walk_end ? S_IDLE : S_UA;
					end else begin
						state_q <= S_UB;
					end
				end
				S_UB: begin
					a_q     <= rd_q;
					state_q <= S_UW;
				end
				S_UW: begin
					ri_q    <= nxt_ri;
					ci_q    <= nxt_ci;
					state_q <= walk_end ? S_IDLE : S_UA;
				end
				S_RPOP: begin
					if (rsp_q == '0) begin
						done_q         <= 1'b1;
						res_q.rect_min <= acc_q.min_v;
						res_q.rect_max <= acc_q.max_v;
						state_q        <= S_IDLE;
					end else if (r_disj) begin
						rsp_q <= rsp_m1;
					end else if (r_cov) begin
						rsp_q        <= rsp_m1;
						vx_q         <= rv;
						cs_node_q[0] <= '0;
						cs_lo_q[0]   <= '0;
						cs_hi_q[0]   <= COL_LAST;
						csp_q        <= CSPW'(1);
						state_q      <= S_CPOP;
					end else begin
						// Right child under, left child on top.
						rs_node_q[rtop]  <= RNW'({1'b0, rv} << 1) + RNW'(2);
						rs_lo_q[rtop]    <= rm + 1'b1;
						rs_hi_q[rtop]    <= re;
						rs_node_q[rpush] <= RNW'({1'b0, rv} << 1) + RNW'(1);
						rs_lo_q[rpush]   <= rs;
						rs_hi_q[rpush]   <= rm;
						rsp_q            <= rsp_q + 1'b1;
					end
				end
				S_CPOP: begin
					if (csp_q == '0) begin
						state_q <= S_RPOP;
					end else if (c_disj) begin
						csp_q <= csp_m1;
					end else if (c_cov) begin
						csp_q   <= csp_m1;
						state_q <= S_CWAIT;
					end else begin
						cs_node_q[ctop]  <= CNW'({1'b0, cv} << 1) + CNW'(2);
						cs_lo_q[ctop]    <= cm + 1'b1;
						cs_hi_q[ctop]    <= ce;
						cs_node_q[cpush] <= CNW'({1'b0, cv} << 1) + CNW'(1);
						cs_lo_q[cpush]   <= cs;
						cs_hi_q[cpush]   <= cm;
						csp_q            <= csp_q + 1'b1;
					end
				end
				S_CWAIT: begin
					acc_q   <= rmm2d_pkg::merge(acc_q, rd_q);
					state_q <= S_CPOP;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

>>> design/rmm2d_checker.sv
// ============================================================================
// Two-dimensional min/max segment tree: port checker
// Watches the command and result ports of the top level over time.
// ============================================================================
module rmm2d_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input rmm2d_pkg::in_t  cmd,
	input logic            done,
	input rmm2d_pkg::out_t result
);

	// A result beat only follows an accepted beat or work in progress.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result beat without a cause");

	// A result beat is shown only once the block is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// An update never produces a result beat straight away.
	a_update_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.operation == rmm2d_pkg::OP_UPDATE) |=> !done)
		else $error("update produced a result");

	// An empty rectangle answers at once with the identities.
	a_empty_query: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.operation == rmm2d_pkg::OP_QUERY
		&& (cmd.row_low > cmd.row_high || cmd.col_low > cmd.col_high))
		|=> (done && result.rect_min == rmm2d_pkg::INT_MAX
		&& result.rect_max == rmm2d_pkg::INT_MIN))
		else $error("empty rectangle gave a wrong result");

endmodule

bind rect_min_max_2d_segment_tree rmm2d_checker u_rmm2d_checker (.*);
